@@ rtl/core/wtisc_pkg.sv @@
// ----------------------------------------------------------------------------
// wtisc_pkg
// Shared types and constants for the two-wheel speed controller: event
// kinds, register indexes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package wtisc_pkg;

    localparam int AVG_SAMPLES_DEF  = 6;
    localparam int CAPTURE_BITS_DEF = 16;
    localparam int DIV_BITS         = 32;

    localparam logic signed [31:0] SPEED_SCALE   = 32'sd12000000;
    localparam logic signed [15:0] STOP_LIMIT_Q8 = -16'sd25600;

    localparam logic [9:0]  BASE_SPEED_RST    = 10'd50;
    localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd256;
    localparam logic [9:0]  DRIVE_MAX_RST     = 10'd720;
    localparam logic [9:0]  DRIVE_MIN_RST     = 10'd20;

    typedef enum logic [1:0] {
        KIND_OVERFLOW = 2'd0,
        KIND_LEFT     = 2'd1,
        KIND_RIGHT    = 2'd2,
        KIND_TICK     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_BASE_SPEED    = 2'd0,
        REG_INTEGRAL_GAIN = 2'd1,
        REG_DRIVE_MAX     = 2'd2,
        REG_DRIVE_MIN     = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_AVG_CHECK,
        ST_AVG_WAIT,
        ST_SPEED,
        ST_SPEED_WAIT,
        ST_ERROR,
        ST_MULT,
        ST_DRIVE,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_OVERFLOW,
        CMD_CAPTURE,
        CMD_AVG_START,
        CMD_AVG_STORE,
        CMD_TARGET,
        CMD_SPEED_START,
        CMD_SPEED_ZERO,
        CMD_SPEED_STORE,
        CMD_ERROR,
        CMD_MULT,
        CMD_DRIVE,
        CMD_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    wheel;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  avg_due;
        logic  avg_zero;
        logic  div_done;
    } dp_status_t;

endpackage

@@ rtl/core/wtisc_div.sv @@
// ----------------------------------------------------------------------------
// wtisc_div
// Signed restoring divider, one quotient bit per cycle, truncates toward
// zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module wtisc_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import wtisc_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [31:0]      quo_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      dvs_reg;
    logic [32:0]      rem_sh;
    logic [32:0]      diff;

    assign rem_sh   = {rem_reg[31:0], quo_reg[31]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[31] ^ divisor[31];
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg <= divisor[31] ? (32'd0 - divisor) : divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule

@@ rtl/core/wtisc_dp.sv @@
// ----------------------------------------------------------------------------
// wtisc_dp
// Datapath: configuration, per-wheel period extension and averaging,
// speed, saturating error integral, gain multiply, drive clamp.
// ----------------------------------------------------------------------------
module wtisc_dp #(
    parameter int AVG_SAMPLES  = wtisc_pkg::AVG_SAMPLES_DEF,
    parameter int CAPTURE_BITS = wtisc_pkg::CAPTURE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wtisc_pkg::ctrl_cmd_t    cmd,
    output wtisc_pkg::dp_status_t   status,
    input  logic [1:0]              kind,
    input  logic [CAPTURE_BITS-1:0] capture_value,
    input  logic signed [15:0]      diff_speed,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [15:0]             wr_data,
    output logic [9:0]              drive_left,
    output logic [9:0]              drive_right
);
    import wtisc_pkg::*;

    localparam logic [31:0] EXT_INC =
        (CAPTURE_BITS >= 32) ? 32'd0 : 32'(64'd1 << CAPTURE_BITS);

    // ceil(2^35 / AVG_SAMPLES): exact floor quotient for any 32-bit magnitude
    localparam logic [35:0] AVG_RECIP =
        36'(((64'd1 << 35) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    logic [9:0]  base_reg;
    logic [15:0] ki_reg;
    logic [9:0]  max_reg;
    logic [9:0]  min_reg;

    logic [31:0] ext_reg  [2];
    logic [31:0] sum_reg  [2];
    logic [2:0]  cnt_reg  [2];
    logic [31:0] avg_reg  [2];
    logic [31:0] esum_reg [2];

    kind_t                     kind_reg;
    logic [CAPTURE_BITS-1:0]   cap_reg;
    logic signed [15:0]        diff_reg;
    logic signed [19:0]        tgt_reg [2];
    logic signed [31:0]        speed_reg;
    logic signed [31:0]        s_reg;
    logic signed [48:0]        prod_reg;
    logic [9:0]                res_reg [2];
    logic [9:0]                drive_left_reg;
    logic [9:0]                drive_right_reg;

    logic [1:0]                cdv_cnt_reg;
    logic                      cdv_done_reg;
    logic                      cdv_neg_reg;
    logic [31:0]               cdv_abs_reg;
    logic [50:0]               cdv_acc_reg;
    logic [31:0]               cdv_quo_reg;

    logic               w;
    logic [31:0]        period;
    logic signed [19:0] base_q8;
    logic               stop;
    logic signed [35:0] err_raw;
    logic signed [31:0] s_next;
    logic signed [49:0] acc;
    logic signed [49:0] acc_adj;
    logic signed [33:0] v;
    logic [9:0]         res_next;
    logic               div_start;
    logic [31:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [31:0]        div_quo;

    assign w       = cmd.wheel;
    assign period  = ext_reg[w] + 32'(cap_reg);
    assign base_q8 = signed'({2'b00, base_reg, 8'h00});
    assign stop    = diff_reg < STOP_LIMIT_Q8;

    assign status.kind     = kind_reg;
    assign status.avg_due  = cnt_reg[w] == 3'(AVG_SAMPLES);
    assign status.avg_zero = avg_reg[w] == 32'd0;
    assign status.div_done = div_done || cdv_done_reg;

    assign div_start    = cmd.op == CMD_SPEED_START;
    assign div_dividend = SPEED_SCALE;
    assign div_divisor  = avg_reg[w];

    wtisc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        err_raw = 36'(signed'(esum_reg[w])) + 36'(tgt_reg[w]) - (36'(speed_reg) <<< 8);
        if (err_raw > 36'sh07FFFFFFF)
        begin
            s_next = 32'sh7FFFFFFF;
        end
        else if (err_raw < -36'sh080000000)
        begin
            s_next = -32'sh80000000;
        end
        else
        begin
            s_next = 32'(err_raw);
        end

        acc     = (50'(tgt_reg[w]) <<< 8) + 50'(prod_reg);
        acc_adj = acc[49] ? (acc + 50'sd65535) : acc;
        v       = 34'(acc_adj >>> 16);
        if (v > signed'({24'd0, max_reg}))
        begin
            v = signed'({24'd0, max_reg});
        end
        if (v < signed'({24'd0, min_reg}))
        begin
            v = signed'({24'd0, min_reg});
        end
        res_next = v[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_SPEED_RST;
            ki_reg   <= INTEGRAL_GAIN_RST;
            max_reg  <= DRIVE_MAX_RST;
            min_reg  <= DRIVE_MIN_RST;
            for (int i = 0; i < 2; i++)
            begin
                ext_reg[i]  <= '0;
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                avg_reg[i]  <= '0;
                esum_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                unique case (reg_index_t'(wr_index))
                    REG_BASE_SPEED:    base_reg <= wr_data[9:0];
                    REG_INTEGRAL_GAIN: ki_reg   <= wr_data;
                    REG_DRIVE_MAX:     max_reg  <= wr_data[9:0];
                    REG_DRIVE_MIN:     min_reg  <= wr_data[9:0];
                endcase
            end
            unique case (cmd.op)
                CMD_OVERFLOW:
                begin
                    ext_reg[0] <= ext_reg[0] + EXT_INC;
                    ext_reg[1] <= ext_reg[1] + EXT_INC;
                end
                CMD_CAPTURE:
                begin
                    ext_reg[w] <= 32'd0 - 32'(cap_reg);
                    sum_reg[w] <= sum_reg[w] + period;
                    cnt_reg[w] <= cnt_reg[w] + 3'd1;
                end
                CMD_AVG_STORE:
                begin
                    avg_reg[w] <= cdv_quo_reg;
                    sum_reg[w] <= '0;
                    cnt_reg[w] <= '0;
                end
                CMD_ERROR:
                begin
                    esum_reg[w] <= s_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // average: reciprocal multiply split into two 32x18 products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cdv_cnt_reg  <= '0;
            cdv_done_reg <= 1'b0;
        end
        else
        begin
            cdv_done_reg <= cdv_cnt_reg == 2'd3;
            if (cmd.op == CMD_AVG_START)
            begin
                cdv_cnt_reg <= 2'd1;
            end
            else if (cdv_cnt_reg != 2'd0)
            begin
                cdv_cnt_reg <= cdv_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_AVG_START)
        begin
            cdv_neg_reg <= sum_reg[w][31];
            cdv_abs_reg <= sum_reg[w][31] ? (32'd0 - sum_reg[w]) : sum_reg[w];
        end
        unique case (cdv_cnt_reg)
            2'd1:
            begin
                cdv_acc_reg <= 51'(cdv_abs_reg) * 51'(AVG_RECIP[17:0]);
            end
            2'd2:
            begin
                cdv_acc_reg <= (cdv_acc_reg >> 18)
                             + 51'(cdv_abs_reg) * 51'(AVG_RECIP[35:18]);
            end
            2'd3:
            begin
                cdv_quo_reg <= cdv_neg_reg ? (32'd0 - 32'(cdv_acc_reg >> 17))
                                           : 32'(cdv_acc_reg >> 17);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CMD_LOAD:
            begin
                kind_reg <= kind_t'(kind);
                cap_reg  <= capture_value;
                diff_reg <= diff_speed;
            end
            CMD_TARGET:
            begin
                tgt_reg[0] <= stop ? 20'sd0 : base_q8 + 20'(diff_reg);
                tgt_reg[1] <= stop ? 20'sd0 : base_q8 - 20'(diff_reg);
            end
            CMD_SPEED_ZERO:  speed_reg <= '0;
            CMD_SPEED_STORE: speed_reg <= div_quo;
            CMD_ERROR:       s_reg     <= s_next;
            CMD_MULT:        prod_reg  <= 49'(signed'({1'b0, ki_reg})) * 49'(s_reg);
            CMD_DRIVE:       res_reg[w] <= res_next;
            CMD_OUT:
            begin
                drive_left_reg  <= res_reg[0];
                drive_right_reg <= res_reg[1];
            end
            default:
            begin
            end
        endcase
    end

    assign drive_left  = drive_left_reg;
    assign drive_right = drive_right_reg;

endmodule

@@ rtl/core/wtisc_ctrl.sv @@
// ----------------------------------------------------------------------------
// wtisc_ctrl
// Controller: sequences event handling, divider use and per-wheel control
// steps, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module wtisc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output wtisc_pkg::ctrl_cmd_t  cmd,
    input  wtisc_pkg::dp_status_t status
);
    import wtisc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   w_reg;
    logic   w_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            w_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = CMD_NONE;
        cmd.wheel      = w_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.kind)
                    KIND_OVERFLOW:
                    begin
                        cmd.op     = CMD_OVERFLOW;
                        state_next = ST_IDLE;
                    end
                    KIND_LEFT, KIND_RIGHT:
                    begin
                        cmd.op     = CMD_CAPTURE;
                        cmd.wheel  = status.kind == KIND_RIGHT;
                        w_next     = status.kind == KIND_RIGHT;
                        state_next = ST_AVG_CHECK;
                    end
                    KIND_TICK:
                    begin
                        cmd.op     = CMD_TARGET;
                        w_next     = 1'b0;
                        state_next = ST_SPEED;
                    end
                endcase
            end
            ST_AVG_CHECK:
            begin
                if (status.avg_due)
                begin
                    cmd.op     = CMD_AVG_START;
                    state_next = ST_AVG_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = CMD_AVG_STORE;
                    state_next = ST_IDLE;
                end
            end
            ST_SPEED:
            begin
                if (status.avg_zero)
                begin
                    cmd.op     = CMD_SPEED_ZERO;
                    state_next = ST_ERROR;
                end
                else
                begin
                    cmd.op     = CMD_SPEED_START;
                    state_next = ST_SPEED_WAIT;
                end
            end
            ST_SPEED_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = CMD_SPEED_STORE;
                    state_next = ST_ERROR;
                end
            end
            ST_ERROR:
            begin
                cmd.op     = CMD_ERROR;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.op     = CMD_MULT;
                state_next = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                cmd.op = CMD_DRIVE;
                if (w_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    w_next     = 1'b1;
                    state_next = ST_SPEED;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/wheel_tach_integral_speed_control.sv @@
// ----------------------------------------------------------------------------
// wheel_tach_integral_speed_control
// Two-wheel encoder speed controller with saturating integral control.
// An overflow extends both wheel periods; a capture may also complete an
// average. A control tick sets both targets, then runs one pass per wheel,
// with a serial divide for speed unless that wheel's average is zero.
// One request at a time; a held result delays the next tick's output.
// Reset clears the per-wheel period, sum, count, average and integral state
// and loads register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module wheel_tach_integral_speed_control #(
    parameter int AVG_SAMPLES  = wtisc_pkg::AVG_SAMPLES_DEF,
    parameter int CAPTURE_BITS = wtisc_pkg::CAPTURE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              kind,
    input  logic [CAPTURE_BITS-1:0] capture_value,
    input  logic signed [15:0]      diff_speed,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [9:0]              drive_left,
    output logic [9:0]              drive_right,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [15:0]             wr_data
);
    import wtisc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    wtisc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    wtisc_dp #(
        .AVG_SAMPLES  (AVG_SAMPLES),
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .capture_value (capture_value),
        .diff_speed    (diff_speed),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .drive_left    (drive_left),
        .drive_right   (drive_right)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted request did not start work");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == CMD_OUT |-> in_stall)
        else $error("result loaded while idle");

    a_div_store: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == CMD_AVG_STORE || cmd.op == CMD_SPEED_STORE |-> status.div_done)
        else $error("quotient stored before divider finished");

endmodule

@@ test/wheel_speed_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_scoreboard
// Predicts the drive outputs of the two-wheel speed controller from the
// accepted requests and checks each delivered drive pair against the oldest
// prediction.
// ----------------------------------------------------------------------------
class wheel_speed_scoreboard;

    typedef struct {
        logic [9:0] left;
        logic [9:0] right;
    } drive_pair_t;

    logic [9:0]  base_speed;
    logic [15:0] gain;
    logic [9:0]  drv_max;
    logic [9:0]  drv_min;

    logic [31:0] ext_l, ext_r, sum_l, sum_r, avg_l, avg_r, esum_l, esum_r;
    logic [2:0]  cnt_l, cnt_r;

    drive_pair_t pending_drives[$];
    int          errors;

    function new();
        base_speed = wtisc_pkg::BASE_SPEED_RST;
        gain       = wtisc_pkg::INTEGRAL_GAIN_RST;
        drv_max    = wtisc_pkg::DRIVE_MAX_RST;
        drv_min    = wtisc_pkg::DRIVE_MIN_RST;
        ext_l = '0; ext_r = '0; sum_l = '0; sum_r = '0;
        avg_l = '0; avg_r = '0; esum_l = '0; esum_r = '0;
        cnt_l = '0; cnt_r = '0;
        errors = 0;
    endfunction

    function void write_reg(wtisc_pkg::reg_index_t idx, logic [15:0] data);
        case (idx)
            wtisc_pkg::REG_BASE_SPEED:    base_speed = data[9:0];
            wtisc_pkg::REG_INTEGRAL_GAIN: gain = data;
            wtisc_pkg::REG_DRIVE_MAX:     drv_max = data[9:0];
            wtisc_pkg::REG_DRIVE_MIN:     drv_min = data[9:0];
        endcase
    endfunction

    function void capture(ref logic [31:0] ext, ref logic [31:0] sum,
                          ref logic [2:0] cnt, ref logic [31:0] avg,
                          input logic [15:0] cap);
        logic [31:0] period;
        period = ext + {16'd0, cap};
        ext = 32'd0 - {16'd0, cap};
        sum = sum + period;
        cnt = cnt + 3'd1;
        if (cnt == 3'd6)
        begin
            avg = $signed(sum) / 32'sd6;
            cnt = '0;
            sum = '0;
        end
    endfunction

    function logic [9:0] drive(longint target, logic [31:0] avg,
                               ref logic [31:0] esum);
        longint a, spd, s, v;
        a = longint'($signed(avg));
        spd = (a == 64'sd0) ? 64'sd0 : (64'sd12000000 / a);
        s = longint'($signed(esum)) + target - spd * 256;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        esum = s[31:0];
        v = (target * 256 + longint'(gain) * s) / 65536;
        if (v > longint'(drv_max)) v = longint'(drv_max);
        if (v < longint'(drv_min)) v = longint'(drv_min);
        return v[9:0];
    endfunction

    function void note_request(wtisc_pkg::kind_t k, logic [15:0] cap,
                               logic signed [15:0] diff);
        drive_pair_t p;
        longint tl, tr;
        case (k)
            wtisc_pkg::KIND_OVERFLOW:
            begin
                ext_l += 32'h10000;
                ext_r += 32'h10000;
            end
            wtisc_pkg::KIND_LEFT:  capture(ext_l, sum_l, cnt_l, avg_l, cap);
            wtisc_pkg::KIND_RIGHT: capture(ext_r, sum_r, cnt_r, avg_r, cap);
            default:
            begin
                tl = '0;
                tr = '0;
                if (diff >= -16'sd25600)
                begin
                    tl = longint'(base_speed) * 256 + longint'(diff);
                    tr = longint'(base_speed) * 256 - longint'(diff);
                end
                p.right = drive(tr, avg_r, esum_r);
                p.left  = drive(tl, avg_l, esum_l);
                pending_drives.push_back(p);
            end
        endcase
    endfunction

    function void check_drive(logic [9:0] left, logic [9:0] right);
        drive_pair_t p;
        if (pending_drives.size() == 0)
        begin
            $display("%0t: unexpected drive pair %0d %0d", $time, left, right);
            errors++;
            return;
        end
        p = pending_drives.pop_front();
        if (left !== p.left)
        begin
            $display("%0t: drive_left expected %0d actual %0d", $time, p.left, left);
            errors++;
        end
        if (right !== p.right)
        begin
            $display("%0t: drive_right expected %0d actual %0d", $time, p.right, right);
            errors++;
        end
    endfunction

endclass

@@ test/wheel_tach_integral_speed_control_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_tach_integral_speed_control_test
// Drives encoder events and control ticks through several register settings
// with random idle and stall gaps; a scoreboard checks every drive pair.
// ----------------------------------------------------------------------------
module wheel_tach_integral_speed_control_test;
    import wtisc_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [1:0]         kind = 0;
    logic [15:0]        capture_value = 0;
    logic signed [15:0] diff_speed = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [9:0]         drive_left, drive_right;
    logic               wr_en = 0;
    logic [1:0]         wr_index = 0;
    logic [15:0]        wr_data = 0;

    wheel_speed_scoreboard board = new();
    bit stall_enable = 1;

    wheel_tach_integral_speed_control dut (.*);

    always #2 clk = ~clk;

    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_drive(drive_left, drive_right);
        out_stall <= stall_enable && ($urandom_range(0, 5) > 2);
    end

    // hold valid after an accept; drop it only when idling before the next
    task automatic send(kind_t k, logic [15:0] cap, logic signed [15:0] diff);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        capture_value <= cap;
        diff_speed <= diff;
        do @(posedge clk); while (in_stall);
        board.note_request(k, cap, diff);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending_drives.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] data);
        wr_en <= 1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic random_event();
        int r;
        logic signed [15:0] d;
        r = $urandom_range(0, 9);
        d = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, 12000)) - 16'd6000;
        if (r < 2) send(KIND_OVERFLOW, 16'd0, 16'($urandom));
        else if (r < 5) send(KIND_LEFT, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                             : 16'($urandom_range(1000, 4000)), 16'($urandom));
        else if (r < 8) send(KIND_RIGHT, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                              : 16'($urandom_range(1000, 4000)), 16'($urandom));
        else send(KIND_TICK, 16'($urandom), d);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(KIND_TICK, 16'd0, 16'sd0);
        send(KIND_TICK, 16'hFFFF, 16'sd32767);
        send(KIND_TICK, 16'd0, -16'sd32768);
        send(KIND_TICK, 16'd0, -16'sd25600);
        send(KIND_TICK, 16'd0, -16'sd25601);
        for (int i = 0; i < 6; i++)
        begin
            send(KIND_LEFT, (i == 0) ? 16'hFFFF : 16'd0, 16'sd0);
            send(KIND_RIGHT, 16'(2000 + i), 16'sd0);
        end
        send(KIND_OVERFLOW, 16'd0, 16'sd0);
        send(KIND_TICK, 16'd0, 16'sh0100);
        send(KIND_TICK, 16'd0, -16'sh0100);
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_BASE_SPEED, 16'hFC00 | 10'd1023);
                    write_reg(REG_INTEGRAL_GAIN, 16'hFFFF);
                    write_reg(REG_DRIVE_MAX, 16'd800);
                    write_reg(REG_DRIVE_MIN, 16'd0);
                end
                1:
                begin
                    write_reg(REG_BASE_SPEED, 16'd0);
                    write_reg(REG_INTEGRAL_GAIN, 16'd0);
                    write_reg(REG_DRIVE_MAX, 16'd0);
                    write_reg(REG_DRIVE_MIN, 16'd800);
                end
                default:
                begin
                    write_reg(REG_BASE_SPEED, 16'($urandom));
                    write_reg(REG_INTEGRAL_GAIN, 16'($urandom_range(0, 1024)));
                    write_reg(REG_DRIVE_MAX, 16'($urandom_range(0, 800)));
                    write_reg(REG_DRIVE_MIN, 16'($urandom_range(0, 100)));
                end
            endcase
            wr_en <= 0;
            stall_enable = (phase != 3);
            for (int i = 0; i < 280; i++)
            begin
                random_event();
                if (i == 140) drain();
            end
            drain();
        end
        drain();
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
